FILE: hw/rtl/pva_pkg.sv
// Shared types and constants for the priority voice allocator.
// Used by pva_cell, pva_ctrl and priority_voice_allocator; no dependencies.

package pva_pkg;

  localparam int NUM_VOICES = 6;            // size of the voice pool, 2 to 8

  localparam int VOICE_W = 3;               // width of voice_sel / granted_voice
  localparam int SND_W   = 8;               // sound_id width
  localparam int LEVEL_W = 4;               // priority level width
  localparam int STAMP_W = 32;              // start stamp / start counter width
  localparam int PATCH_W = SND_W + 1;       // loaded patch, all ones = no patch

  localparam logic [PATCH_W-1:0] NO_PATCH  = '1;
  localparam logic [VOICE_W:0]   SEL_LIMIT = (VOICE_W + 1)'(NUM_VOICES);

  // Request codes carried on in_tuser.
  typedef enum logic [1:0] {
    REQ_NOTE_ON  = 2'd0,
    REQ_NOTE_OFF = 2'd1,
    REQ_FX_PLAY  = 2'd2,
    REQ_FX_DONE  = 2'd3
  } pva_req_t;

  // Request context broadcast to every cell while a search runs.
  typedef struct packed {
    logic               is_fx;
    logic [LEVEL_W-1:0] pri;
  } pva_scan_t;

  // Best candidate so far, handed from cell to cell.
  typedef struct packed {
    logic               valid;
    logic               found;
    logic               free;
    logic [VOICE_W-1:0] idx;
    logic [LEVEL_W-1:0] level;
    logic [STAMP_W-1:0] stamp;
    logic               busy;
    logic               is_eff;
    logic [PATCH_W-1:0] patch;
  } pva_carry_t;

  // Update command broadcast to the cells; rel frees the voice.
  typedef struct packed {
    logic               en;
    logic               rel;
    logic [VOICE_W-1:0] idx;
    logic [LEVEL_W-1:0] level;
    logic               is_eff;
    logic [STAMP_W-1:0] stamp;
    logic [PATCH_W-1:0] patch;
  } pva_wr_t;

  // Result item, laid out so that accepted sits in bit 0.
  typedef struct packed {
    logic               stole_effect;
    logic               patch_load;
    logic               key_off_first;
    logic [VOICE_W-1:0] granted_voice;
    logic               accepted;
  } pva_res_t;

endpackage

FILE: hw/rtl/pva_cell.sv
// One voice slot: holds the voice state and takes part in the search chain.
// Depends on pva_pkg.

module pva_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pva_pkg::VOICE_W-1:0] cell_idx,
  input  pva_pkg::pva_scan_t          scan,
  input  pva_pkg::pva_wr_t            wr,
  input  pva_pkg::pva_carry_t         carry_in,
  output pva_pkg::pva_carry_t         carry_out
);

  logic                        busy_r;
  logic [pva_pkg::LEVEL_W-1:0] level_r;
  logic                        eff_r;
  logic [pva_pkg::STAMP_W-1:0] stamp_r;
  logic [pva_pkg::PATCH_W-1:0] patch_r;
  pva_pkg::pva_carry_t         carry_r;
  pva_pkg::pva_carry_t         carry_nxt;

  logic take_free;
  logic older;
  logic fx_better;
  logic steal_ok;
  logic hit;

  // A free slot wins unless an earlier free slot already did.
  assign take_free = !busy_r && !carry_in.free;
  assign older     = !carry_in.found || (stamp_r < carry_in.stamp);
  assign fx_better = (level_r <= scan.pri) &&
                     (!carry_in.found || (level_r < carry_in.level) ||
                      ((level_r == carry_in.level) && (stamp_r < carry_in.stamp)));
  assign steal_ok  = busy_r && !carry_in.free && (scan.is_fx ? fx_better : older);
  assign hit       = wr.en && (wr.idx == cell_idx);

  always_comb begin
    carry_nxt = carry_in;
    if (take_free || steal_ok) begin
      carry_nxt.found  = 1'b1;
      carry_nxt.free   = !busy_r;
      carry_nxt.idx    = cell_idx;
      carry_nxt.level  = level_r;
      carry_nxt.stamp  = stamp_r;
      carry_nxt.busy   = busy_r;
      carry_nxt.is_eff = eff_r;
      carry_nxt.patch  = patch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      level_r <= '0;
      eff_r   <= 1'b0;
      stamp_r <= '0;
      patch_r <= pva_pkg::NO_PATCH;
      carry_r <= '0;
    end else begin
      carry_r <= carry_nxt;
      if (hit) begin
        if (wr.rel) begin
          busy_r  <= 1'b0;
          level_r <= '0;
          eff_r   <= 1'b0;
        end else begin
          busy_r  <= 1'b1;
          level_r <= wr.level;
          eff_r   <= wr.is_eff;
          stamp_r <= wr.stamp;
          patch_r <= wr.patch;
        end
      end
    end
  end

  assign carry_out = carry_r;

endmodule

FILE: hw/rtl/pva_ctrl.sv
// Request sequencer: stream handshakes, config register, start counter and
// the update commands for the cell row. Depends on pva_pkg.

module pva_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_tuser,   // req_type
  input  logic [15:0]         in_tdata,   // voice_sel, sound_id, req_priority, asset_ready
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // accepted, granted_voice, key_off_first,
                                          // patch_load, stole_effect, zero pad
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_data,   // cache_mode
  output pva_pkg::pva_carry_t carry_start,
  input  pva_pkg::pva_carry_t carry_end,
  output pva_pkg::pva_scan_t  scan,
  output pva_pkg::pva_wr_t    wr
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_HOLD} state_t;

  state_t                      state_r, state_nxt;
  pva_pkg::pva_scan_t          scan_r, scan_nxt;
  logic [pva_pkg::SND_W-1:0]   snd_r, snd_nxt;
  logic [pva_pkg::STAMP_W-1:0] cnt_r, cnt_nxt;
  pva_pkg::pva_res_t           res_r, res_nxt;
  pva_pkg::pva_res_t           out_data_r, out_data_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        cache_r, cache_nxt;

  pva_pkg::pva_req_t           req;
  logic [pva_pkg::VOICE_W-1:0] sel;
  logic [pva_pkg::SND_W-1:0]   snd;
  logic [pva_pkg::LEVEL_W-1:0] pri;
  logic                        ready;
  logic [pva_pkg::STAMP_W-1:0] stamp_new;

  assign req       = pva_pkg::pva_req_t'(in_tuser);
  assign sel       = in_tdata[2:0];
  assign snd       = in_tdata[10:3];
  assign pri       = in_tdata[14:11];
  assign ready     = in_tdata[15];
  assign stamp_new = cnt_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    snd_nxt       = snd_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    cache_nxt     = cache_r;
    wr            = '0;
    carry_start   = '0;

    if (cfg_valid) begin
      cache_nxt = cfg_data[0];
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_nxt = '0;
          if (req == pva_pkg::REQ_NOTE_OFF || req == pva_pkg::REQ_FX_DONE) begin
            if ({1'b0, sel} < pva_pkg::SEL_LIMIT) begin
              wr.en                 = 1'b1;
              wr.rel                = 1'b1;
              wr.idx                = sel;
              res_nxt.accepted      = 1'b1;
              res_nxt.granted_voice = sel;
              res_nxt.key_off_first = 1'b1;
            end
            state_nxt = S_HOLD;
          end else if (cache_r || !ready) begin
            state_nxt = S_HOLD;
          end else begin
            carry_start.valid = 1'b1;
            scan_nxt.is_fx    = (req == pva_pkg::REQ_FX_PLAY);
            scan_nxt.pri      = pri;
            snd_nxt           = snd;
            state_nxt         = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (carry_end.valid) begin
          res_nxt = '0;
          if (carry_end.found) begin
            wr.en                 = 1'b1;
            wr.idx                = carry_end.idx;
            wr.stamp              = stamp_new;
            cnt_nxt               = stamp_new;
            res_nxt.accepted      = 1'b1;
            res_nxt.granted_voice = carry_end.idx;
            res_nxt.stole_effect  = carry_end.busy && carry_end.is_eff;
            if (scan_r.is_fx) begin
              wr.level              = scan_r.pri;
              wr.is_eff             = 1'b1;
              wr.patch              = pva_pkg::NO_PATCH;
              res_nxt.key_off_first = 1'b1;
            end else begin
              wr.patch              = {1'b0, snd_r};
              res_nxt.key_off_first = carry_end.busy;
              res_nxt.patch_load    = (carry_end.patch != {1'b0, snd_r});
            end
          end
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_r      <= '0;
      snd_r       <= '0;
      cnt_r       <= '0;
      res_r       <= '0;
      out_data_r  <= '0;
      out_valid_r <= 1'b0;
      cache_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      snd_r       <= snd_nxt;
      cnt_r       <= cnt_nxt;
      res_r       <= res_nxt;
      out_data_r  <= out_data_nxt;
      out_valid_r <= out_valid_nxt;
      cache_r     <= cache_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};
  // The first cell judges the request in its accept cycle, so it needs the new context.
  assign scan       = scan_nxt;

  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.en && !wr.rel) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("start counter did not advance by one on a grant");

  a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    carry_end.valid |-> (state_r == S_SCAN))
    else $error("search token left the cell row outside a search");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && carry_end.valid) |=> (state_r == S_HOLD))
    else $error("search end not followed by result hold");

  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> ((state_r == S_IDLE && in_tvalid) || carry_end.valid))
    else $error("voice update issued outside a request");

endmodule

FILE: hw/rtl/priority_voice_allocator.sv
// Top level of the priority voice allocator: sequencer plus a row of voice cells.
// Depends on pva_pkg, pva_cell and pva_ctrl.

// Allocates a pool of pva_pkg::NUM_VOICES synthesizer voices. Each request on
// the input stream (req_type on in_tuser) yields exactly one result transaction.
// Note-on takes the lowest-numbered free voice, else the least recently started
// one; effect-play takes the lowest free voice, else the busy voice with the
// lowest level at or below its priority (older first, then lower index).
// Note-off and effect-finished free the named voice in any mode. cache_mode,
// written on the cfg_ port, refuses note-on and effect-play. A refused request
// returns all-zero fields. Timing: a release or refused request goes straight
// to the result hold; a note-on or effect-play sends a search token down the
// cell row, one cell per cycle, and waits for it to leave the row. The result
// waits in an output register; the next request is taken while it is pending.

module priority_voice_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // req_type
  input  logic [15:0] in_tdata,   // [2:0] voice_sel, [10:3] sound_id,
                                  // [14:11] req_priority, [15] asset_ready
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] accepted, [3:1] granted_voice,
                                  // [4] key_off_first, [5] patch_load,
                                  // [6] stole_effect, [7] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data    // cache_mode
);

  // Token path through the row; entry 0 feeds the first cell.
  pva_pkg::pva_carry_t chain [pva_pkg::NUM_VOICES+1];
  pva_pkg::pva_scan_t  scan;
  pva_pkg::pva_wr_t    wr;

  pva_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .carry_start (chain[0]),
    .carry_end   (chain[pva_pkg::NUM_VOICES]),
    .scan        (scan),
    .wr          (wr)
  );

  // One cell per voice; each advances the best candidate by one step a cycle.
  for (genvar i = 0; i < pva_pkg::NUM_VOICES; i++) begin : g_cell
    pva_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (pva_pkg::VOICE_W'(i)),
      .scan      (scan),
      .wr        (wr),
      .carry_in  (chain[i]),
      .carry_out (chain[i+1])
    );
  end

endmodule
